// File: rtl/gsd_pkg.sv
`default_nettype none

package gsd_pkg;

    localparam int unsigned PollW   = 16;
    localparam int unsigned ThrW    = 8;
    localparam int unsigned SettleW = 16;
    localparam int unsigned LimitW  = 15;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned SpeedW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STABLE_THR    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_SETTLE_TIME   = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT   = 2'd3;

    localparam logic [PollW-1:0]   POLL_RST   = 16'd10;
    localparam logic [ThrW-1:0]    THR_RST    = 8'd3;
    localparam logic [SettleW-1:0] SETTLE_RST = 16'd50;
    localparam logic [LimitW-1:0]  LIMIT_RST  = 15'd300;

    // mode encoding: 1 is 4WD, 0 is 2WD
    localparam logic MODE_4WD = 1'b1;
    localparam logic MODE_2WD = 1'b0;

    typedef struct packed {
        logic [PollW-1:0]   poll_interval;
        logic [ThrW-1:0]    stable_thr;
        logic [SettleW-1:0] settle_time;
        logic [LimitW-1:0]  speed_limit;
    } t_cfg;

    typedef struct packed {
        logic             started;
        logic             confirmed;
        logic             candidate;
        logic [ThrW-1:0]  stable_run;
        logic [TimeW-1:0] last_poll;
        logic [TimeW-1:0] cand_start;
        logic             changed;
        logic             blocked;
    } t_state;

endpackage

`default_nettype wire

// File: rtl/gsd_cfg.sv
`default_nettype none

module gsd_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [gsd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [gsd_pkg::CfgDatW-1:0] i_cfg_data,
    output gsd_pkg::t_cfg                    o_cfg
);

    gsd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval <= gsd_pkg::POLL_RST;
            r_cfg.stable_thr    <= gsd_pkg::THR_RST;
            r_cfg.settle_time   <= gsd_pkg::SETTLE_RST;
            r_cfg.speed_limit   <= gsd_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gsd_pkg::REG_POLL_INTERVAL: begin
                    r_cfg.poll_interval <= i_cfg_data[gsd_pkg::PollW-1:0];
                end
                gsd_pkg::REG_STABLE_THR: begin
                    r_cfg.stable_thr <= i_cfg_data[gsd_pkg::ThrW-1:0];
                end
                gsd_pkg::REG_SETTLE_TIME: begin
                    r_cfg.settle_time <= i_cfg_data[gsd_pkg::SettleW-1:0];
                end
                gsd_pkg::REG_SPEED_LIMIT: begin
                    r_cfg.speed_limit <= i_cfg_data[gsd_pkg::LimitW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/gsd_step.sv
`default_nettype none

module gsd_step (
    input  wire gsd_pkg::t_cfg              i_cfg,
    input  wire gsd_pkg::t_state            i_state,
    input  wire logic                       i_level,
    input  wire logic [gsd_pkg::TimeW-1:0]  i_now_ms,
    input  wire logic signed [gsd_pkg::SpeedW-1:0] i_speed,
    input  wire logic                       i_clear_changed,
    output gsd_pkg::t_state                 o_state
);

    logic                       raw;
    logic                       over;
    logic                       due;
    logic                       same;
    logic [gsd_pkg::TimeW-1:0]  poll_diff;
    logic [gsd_pkg::TimeW-1:0]  settle_diff;
    logic [gsd_pkg::ThrW-1:0]   run_nx;
    logic                       settled;
    logic                       qualify;
    logic                       changed0;
    logic signed [gsd_pkg::SpeedW-1:0] limit_s;

    assign raw      = i_level ? gsd_pkg::MODE_2WD : gsd_pkg::MODE_4WD;
    assign limit_s  = $signed({1'b0, i_cfg.speed_limit});
    assign over     = i_speed > limit_s;
    assign changed0 = i_clear_changed ? 1'b0 : i_state.changed;

    assign poll_diff = i_now_ms - i_state.last_poll;
    assign due       = poll_diff >= {{(gsd_pkg::TimeW-gsd_pkg::PollW){1'b0}},
                                     i_cfg.poll_interval};

    assign same = raw == i_state.candidate;
    // a new candidate starts now, so its elapsed time is zero
    assign settle_diff = same ? (i_now_ms - i_state.cand_start) : '0;
    assign settled     = settle_diff >= {{(gsd_pkg::TimeW-gsd_pkg::SettleW){1'b0}},
                                         i_cfg.settle_time};

    always_comb begin
        run_nx = i_state.stable_run;
        if (!same) begin
            run_nx = gsd_pkg::ThrW'(1);
        end else if (i_state.stable_run < i_cfg.stable_thr) begin
            run_nx = i_state.stable_run + gsd_pkg::ThrW'(1);
        end
    end

    assign qualify = (run_nx >= i_cfg.stable_thr) && settled && (raw != i_state.confirmed);

    always_comb begin
        o_state         = i_state;
        o_state.changed = changed0;
        if (!i_state.started) begin
            o_state.started    = 1'b1;
            o_state.confirmed  = raw;
            o_state.candidate  = raw;
            o_state.stable_run = '0;
            o_state.changed    = 1'b1;
            o_state.last_poll  = i_now_ms;
            o_state.cand_start = '0;
            o_state.blocked    = 1'b0;
        end else if (due) begin
            o_state.last_poll  = i_now_ms;
            o_state.candidate  = raw;
            o_state.stable_run = run_nx;
            if (!same) begin
                o_state.cand_start = i_now_ms;
            end
            if (over) begin
                // hold the mode, flag the held-off change
                if (qualify) begin
                    o_state.blocked = 1'b1;
                end
            end else begin
                o_state.blocked = 1'b0;
                if (qualify) begin
                    o_state.confirmed = raw;
                    o_state.changed   = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/gated_switch_debouncer.sv
`default_nettype none

// Debounced two-position drive mode switch with a speed interlock.
// Input channel (i_in_valid / o_in_ready) carries one sample request: raw
// level, millisecond time, signed speed and a clear for the change flag.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// confirmed mode (1 is 4WD), sticky change flag and blocked flag.
// The first request after reset takes the mode straight from the level.
// After acceptance the input register holds the request; once the result register
// is free, the step logic feeds it and the state registers, and o_out_valid rises.
// Throughput is one request per cycle while the receiver does not stall; the state
// update between input and result register is combinational.
// When the receiver stalls, the result register holds and the input register
// takes one more request; o_in_ready drops only while both are full.
// Reset (synchronous, active low) clears state, empties both registers and
// loads the configuration defaults. Configuration writes through i_cfg_we /
// i_cfg_idx / i_cfg_data take effect in the next cycle, with no handshake.
module gated_switch_debouncer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gsd_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  wire logic [gsd_pkg::CfgDatW-1:0]        i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_level,
    input  wire logic [gsd_pkg::TimeW-1:0]          i_now_ms,
    input  wire logic signed [gsd_pkg::SpeedW-1:0]  i_speed,
    input  wire logic                               i_clear_changed,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_four_wheel_drive,
    output logic                                    o_mode_changed,
    output logic                                    o_change_blocked
);

    gsd_pkg::t_cfg   cfg;
    gsd_pkg::t_state r_state;
    gsd_pkg::t_state n_state;

    logic                              r_in_valid;
    logic                              r_level;
    logic [gsd_pkg::TimeW-1:0]         r_now_ms;
    logic signed [gsd_pkg::SpeedW-1:0] r_speed;
    logic                              r_clear;

    logic r_out_valid;
    logic r_fwd;
    logic r_changed;
    logic r_blocked;

    logic advance;
    logic accept;

    gsd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gsd_step u_step (
        .i_cfg           (cfg),
        .i_state         (r_state),
        .i_level         (r_level),
        .i_now_ms        (r_now_ms),
        .i_speed         (r_speed),
        .i_clear_changed (r_clear),
        .o_state         (n_state)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_level  <= i_level;
            r_now_ms <= i_now_ms;
            r_speed  <= i_speed;
            r_clear  <= i_clear_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fwd     <= n_state.confirmed;
            r_changed <= n_state.changed;
            r_blocked <= n_state.blocked;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_four_wheel_drive = r_fwd;
    assign o_mode_changed     = r_changed;
    assign o_change_blocked   = r_blocked;

endmodule

`default_nettype wire

// File: test/gated_switch_debouncer_tb.sv
typedef struct packed {
    logic four_wd;
    logic changed;
    logic blocked;
} t_drive_status;

class t_debounce_scoreboard;
    logic [gsd_pkg::PollW-1:0]   poll_ms;
    logic [gsd_pkg::ThrW-1:0]    thr;
    logic [gsd_pkg::SettleW-1:0] settle_ms;
    logic [gsd_pkg::LimitW-1:0]  limit;

    bit                         started;
    logic                       confirmed;
    logic                       candidate;
    logic [gsd_pkg::ThrW-1:0]   run;
    logic [gsd_pkg::TimeW-1:0]  last_poll;
    logic [gsd_pkg::TimeW-1:0]  cand_start;
    logic                       changed;
    logic                       blocked;

    t_drive_status expected_q[$];
    int errors;
    int results_seen;

    function void reset_state();
        poll_ms    = gsd_pkg::POLL_RST;
        thr        = gsd_pkg::THR_RST;
        settle_ms  = gsd_pkg::SETTLE_RST;
        limit      = gsd_pkg::LIMIT_RST;
        started    = 0;
        confirmed  = gsd_pkg::MODE_2WD;
        candidate  = gsd_pkg::MODE_2WD;
        run        = '0;
        last_poll  = '0;
        cand_start = '0;
        changed    = 0;
        blocked    = 0;
        expected_q.delete();
    endfunction

    function void write_reg(logic [gsd_pkg::CfgIdxW-1:0] idx, logic [gsd_pkg::CfgDatW-1:0] data);
        case (idx)
            gsd_pkg::REG_POLL_INTERVAL: poll_ms   = data[gsd_pkg::PollW-1:0];
            gsd_pkg::REG_STABLE_THR:    thr       = data[gsd_pkg::ThrW-1:0];
            gsd_pkg::REG_SETTLE_TIME:   settle_ms = data[gsd_pkg::SettleW-1:0];
            gsd_pkg::REG_SPEED_LIMIT:   limit     = data[gsd_pkg::LimitW-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(logic level, logic [gsd_pkg::TimeW-1:0] now_ms,
                               logic signed [gsd_pkg::SpeedW-1:0] speed, logic clr);
        logic raw;
        bit over;
        bit qualified;
        int spd;
        int lim;
        logic [gsd_pkg::TimeW-1:0] since_poll;
        logic [gsd_pkg::TimeW-1:0] held;
        t_drive_status want;
        raw = level ? gsd_pkg::MODE_2WD : gsd_pkg::MODE_4WD;
        spd = speed;
        lim = int'(limit);
        over = spd > lim;
        if (clr)
            changed = 0;
        if (!started) begin
            confirmed  = raw;
            candidate  = raw;
            run        = '0;
            changed    = 1;
            last_poll  = now_ms;
            cand_start = '0;
            blocked    = 0;
            started    = 1;
        end else begin
            since_poll = now_ms - last_poll;
            if (since_poll >= {16'd0, poll_ms}) begin
                last_poll = now_ms;
                if (raw == candidate) begin
                    if (run < thr)
                        run = run + 1'b1;
                end else begin
                    candidate  = raw;
                    run        = 1;
                    cand_start = now_ms;
                end
                held = now_ms - cand_start;
                qualified = (run >= thr) && (held >= {16'd0, settle_ms})
                            && (candidate != confirmed);
                // a blocked change holds the confirmed mode and the change flag as they are
                if (qualified && over) begin
                    blocked = 1;
                end else if (!over) begin
                    if (qualified) begin
                        confirmed = candidate;
                        changed   = 1;
                    end
                    blocked = 0;
                end
            end
        end
        want.four_wd = confirmed;
        want.changed = changed;
        want.blocked = blocked;
        expected_q.push_back(want);
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
        errors++;
    endtask

    task check_result(logic fwd, logic chg, logic blk);
        t_drive_status want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %b%b%b with no request outstanding", fwd, chg, blk));
            return;
        end
        want = expected_q.pop_front();
        if (fwd !== want.four_wd)
            report_mismatch($sformatf("four_wheel_drive got %b want %b", fwd, want.four_wd));
        if (chg !== want.changed)
            report_mismatch($sformatf("mode_changed got %b want %b", chg, want.changed));
        if (blk !== want.blocked)
            report_mismatch($sformatf("change_blocked got %b want %b", blk, want.blocked));
    endtask
endclass

module gated_switch_debouncer_tb;
    localparam int IdleLimit = 5000;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [gsd_pkg::CfgIdxW-1:0]          i_cfg_idx = '0;
    logic [gsd_pkg::CfgDatW-1:0]          i_cfg_data = '0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_ready;
    logic                                 i_level = 1'b0;
    logic [gsd_pkg::TimeW-1:0]            i_now_ms = '0;
    logic signed [gsd_pkg::SpeedW-1:0]    i_speed = '0;
    logic                                 i_clear_changed = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic                                 o_four_wheel_drive;
    logic                                 o_mode_changed;
    logic                                 o_change_blocked;

    t_debounce_scoreboard sb;

    logic [gsd_pkg::TimeW-1:0] clock_ms;
    logic                      switch_pos;
    int                        burst_left;
    logic [15:0]               stall_mask;
    logic [3:0]                stall_pos = '0;
    int                        idle_cycles = 0;

    gated_switch_debouncer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_level            (i_level),
        .i_now_ms           (i_now_ms),
        .i_speed            (i_speed),
        .i_clear_changed    (i_clear_changed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_four_wheel_drive (o_four_wheel_drive),
        .o_mode_changed     (o_mode_changed),
        .o_change_blocked   (o_change_blocked)
    );

    always #5 i_clk = ~i_clk;

    // receiver: check accepted results, then pick next ready from the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_four_wheel_drive, o_mode_changed, o_change_blocked);
        if (stall_pos == 4'd0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        i_out_ready <= stall_mask[stall_pos];
        stall_pos <= stall_pos + 1'b1;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("FAIL gated_switch_debouncer");
            $finish;
        end
    end

    task automatic send_request(logic level, logic [gsd_pkg::TimeW-1:0] now_ms,
                                logic [gsd_pkg::SpeedW-1:0] speed, logic clr);
        i_in_valid      <= 1'b1;
        i_level         <= level;
        i_now_ms        <= now_ms;
        i_speed         <= speed;
        i_clear_changed <= clr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(level, now_ms, speed, clr);
    endtask

    task automatic directed_request(logic level, int unsigned dt, int speed, logic clr);
        clock_ms = clock_ms + dt;
        send_request(level, clock_ms, 16'(speed), clr);
    endtask

    task automatic put_reg(logic [gsd_pkg::CfgIdxW-1:0] idx, logic [gsd_pkg::CfgDatW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(logic [15:0] poll, logic [15:0] thr, logic [15:0] settle,
                                  logic [15:0] limit);
        put_reg(gsd_pkg::REG_POLL_INTERVAL, poll);
        put_reg(gsd_pkg::REG_STABLE_THR, thr);
        put_reg(gsd_pkg::REG_SETTLE_TIME, settle);
        put_reg(gsd_pkg::REG_SPEED_LIMIT, limit);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all outstanding results, then let the pipeline sit idle with valid low
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_requests(int count, int flip_odds, int glitch_pct);
        int r;
        int lim;
        int spd;
        int unsigned dt;
        logic level;
        for (int n = 0; n < count; n++) begin
            lim = int'(sb.limit);
            if ($urandom_range(0, flip_odds - 1) == 0)
                switch_pos = ~switch_pos;
            level = ($urandom_range(0, 99) < glitch_pct) ? ~switch_pos : switch_pos;
            r = $urandom_range(0, 99);
            if (r < 65)
                dt = sb.poll_ms + $urandom_range(0, sb.poll_ms / 4 + 5);
            else if (r < 80)
                dt = $urandom_range(0, sb.poll_ms);
            else if (r < 85)
                dt = 0;
            else if (r < 92)
                dt = sb.settle_ms + $urandom_range(0, 20);
            else
                dt = $urandom;
            clock_ms = clock_ms + dt;
            r = $urandom_range(0, 99);
            if (r < 45)
                spd = $urandom_range(0, lim);
            else if (r < 55)
                spd = lim + $urandom_range(0, 1);
            else if (r < 75)
                spd = (lim < 32767) ? $urandom_range(lim + 1, 32767) : lim;
            else if (r < 85)
                spd = -int'($urandom_range(1, 32768));
            else
                spd = $urandom;
            send_request(level, clock_ms, 16'(spd), $urandom_range(0, 3) == 0);
            // hold valid through a burst; at its end, usually drop it for a random gap
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        switch_pos = 1'b0;
        burst_left = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wrap of time, poll not due, blocked change, speed drop
        clock_ms = 32'hFFFF_FFF5;
        directed_request(1'b0, 0, 0, 1'b1);
        directed_request(1'b1, 5, -32768, 1'b1);
        directed_request(1'b1, 5, 32767, 1'b0);
        directed_request(1'b1, 1, 0, 1'b0);
        directed_request(1'b1, 10, 0, 1'b0);
        directed_request(1'b1, 10, 0, 1'b0);
        directed_request(1'b1, 45, 301, 1'b0);
        directed_request(1'b1, 10, 301, 1'b0);
        directed_request(1'b1, 10, 300, 1'b0);
        directed_request(1'b0, 10, 0, 1'b1);
        directed_request(1'b1, 10, 0, 1'b0);
        directed_request(1'b0, 10, -1, 1'b0);
        directed_request(1'b0, 30, -1, 1'b0);
        directed_request(1'b0, 30, -1, 1'b0);
        directed_request(1'b1, 10, 500, 1'b1);
        directed_request(1'b1, 10, 500, 1'b0);
        directed_request(1'b1, 50, 500, 1'b0);
        directed_request(1'b1, 10, 1000, 1'b0);
        directed_request(1'b0, 10, 0, 1'b0);
        directed_request(1'b0, 0, 0, 1'b0);
        directed_request(1'b1, 32'h8000_0000, 32767, 1'b1);
        directed_request(1'b1, 32'h7FFF_FFFF, -32768, 1'b0);
        drain();

        // threshold zero and everything else at its floor
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        random_requests(200, 8, 10);
        drain();

        // every register at its ceiling, upper data bits set to check masking
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_requests(300, 300, 0);
        drain();

        repeat (4) begin
            apply_settings($urandom_range(0, 30), $urandom_range(0, 8),
                           $urandom_range(0, 120), $urandom_range(0, 2000));
            random_requests(200, $urandom_range(3, 15), 10);
            drain();
        end

        apply_settings(gsd_pkg::POLL_RST, gsd_pkg::THR_RST, gsd_pkg::SETTLE_RST,
                       gsd_pkg::LIMIT_RST);
        random_requests(150, 6, 10);
        drain();

        if (sb.errors == 0)
            $display("PASS gated_switch_debouncer");
        else
            $display("FAIL gated_switch_debouncer");
        $finish;
    end
endmodule
